[rtl/core/hsv_to_rgb_converter_core_assert.svh]
// assertion helpers used by the converter core rtl
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define HSV2RGB_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define HSV2RGB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int HUE_STEPS_DEFAULT = 16;
    localparam int DEG_PER_SECTOR    = 60;

    localparam int HUE_W  = 13;
    localparam int FRAC_W = 9;
    localparam int CH_W   = 8;

    localparam int FRAC_ONE = 256;
    localparam int CH_MAX   = 255;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam int SECTOR_W = 3;
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YEL = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YEL_GRN = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GRN_CYN = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYN_BLU = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLU_MAG = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_MAG_RED = 3'd5;
    localparam int SECTOR_COUNT = 6;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        chan_t               cv;
        chan_t               cp;
    } late_side_t;

    function automatic chan_t sat_byte10(input logic [9:0] x);
        return (x > 10'(CH_MAX)) ? chan_t'(CH_MAX) : x[CH_W-1:0];
    endfunction

endpackage

[rtl/core/hsv2rgb_cdiv.sv]
`timescale 1ns / 1ps

// two-stage divide by a constant: reciprocal multiply, then one correction step
module hsv2rgb_cdiv
    import hsv2rgb_pkg::*;
#(
    parameter int XW  = HUE_W,
    parameter int DIV = DEG_PER_SECTOR * HUE_STEPS_DEFAULT,
    localparam int QRAW = $clog2((2 ** XW - 1) / DIV + 1),
    localparam int QW   = (QRAW > 0) ? QRAW : 1,
    localparam int RW   = $clog2(DIV + 1)
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [XW-1:0] x,
    output logic [QW-1:0] q,
    output logic [RW-1:0] r
);

    localparam int SH  = XW;
    localparam int MW  = XW + 1;
    localparam int PW  = XW + MW;
    localparam int RW2 = $clog2(2 * DIV + 1);
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / DIV);

    logic [PW-1:0]  prod_reg, prod_next;
    logic [XW-1:0]  x_reg;
    logic [QW-1:0]  q_reg, q_next, q_est;
    logic [RW-1:0]  r_reg, r_next;
    logic [RW2-1:0] rem_est;
    logic           fix;

    assign prod_next = PW'(x) * PW'(RECIP);

    // estimate is exact or one short
    assign q_est   = prod_reg[SH +: QW];
    assign rem_est = RW2'(x_reg - XW'(q_est * DIV));
    assign fix     = (rem_est >= RW2'(DIV));
    assign q_next  = fix ? (q_est + QW'(1)) : q_est;
    assign r_next  = fix ? RW'(rem_est - RW2'(DIV)) : RW'(rem_est);

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            x_reg    <= x;
            q_reg    <= q_next;
            r_reg    <= r_next;
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

[rtl/core/hsv2rgb_delay.sv]
`timescale 1ns / 1ps

// payload delay line that advances with the pipeline enable
module hsv2rgb_delay
    import hsv2rgb_pkg::*;
#(
    parameter int W = CH_W,
    parameter int N = 2
) (
    input  logic         aclk,
    input  logic         ce,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge aclk) begin
        if (ce) begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

[rtl/core/hsv_to_rgb_converter_core.sv]
`timescale 1ns / 1ps
// hsv to rgb pixel converter, one pixel per clock while the output is not stalled
//
// input stream s_*: one colour per transaction, hue in s_tdata[12:0]
// (1/HUE_STEPS_PER_DEGREE degree, a full turn wraps to zero), saturation in
// [21:13] and value in [30:22], both with 256 meaning 1.0. output stream m_*
// carries red, green and blue bytes in m_tdata[7:0], [15:8] and [23:16].
// the sustained rate is one transaction per cycle while the output is not
// stalled. the path holds pipelined constant dividers for the hue sector
// (hue / span, then mod 6), the p/q/t multipliers, two more constant dividers
// for q and t and the output register.
// the whole pipeline shares one enable: while m_tvalid is high and m_tready
// is low every stage holds and s_tready is low, so nothing is lost or
// repeated. reset (aresetn low, synchronous) empties the pipeline and drops
// m_tvalid; s_tready stays low during reset; data registers are not cleared.
`include "hsv_to_rgb_converter_core_assert.svh"

module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_STEPS_PER_DEGREE = HUE_STEPS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // hue[12:0], saturation[21:13], brightness[30:22]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int SPAN     = DEG_PER_SECTOR * HUE_STEPS_PER_DEGREE;
    localparam int RW       = $clog2(SPAN + 1);
    localparam int QHRAW    = $clog2((2 ** HUE_W - 1) / SPAN + 1);
    localparam int QHW      = (QHRAW > 0) ? QHRAW : 1;
    localparam int NUMW     = $clog2(FRAC_ONE * SPAN + 1);
    localparam int XQW      = NUMW + 1;
    localparam int XPW      = FRAC_W + NUMW;
    localparam int QQRAW    = $clog2((2 ** XQW - 1) / SPAN + 1);
    localparam int QQW      = (QQRAW > 0) ? QQRAW : 1;
    localparam int PPW      = 2 * FRAC_W;
    localparam int VLD_N    = 7;
    localparam logic [NUMW-1:0] NUM_FULL = NUMW'(FRAC_ONE * SPAN);

    logic ce;
    logic [VLD_N-1:0] vld_reg, vld_next;
    logic m_tvalid_reg, m_tvalid_next;

    logic [HUE_W-1:0]  hue0;
    logic [FRAC_W-1:0] sat0, sat_c0, val0;
    logic [FRAC_W-1:0] sat2, val2;
    logic [QHW-1:0]    qh2;
    logic [RW-1:0]     rh2;

    logic [NUMW-1:0]   sr3_reg, sdr3_reg;
    logic [PPW-1:0]    pp3_reg;
    logic [FRAC_W-1:0] val3_reg, val4_reg;
    logic [NUMW-1:0]   numq4_reg, numt4_reg;
    chan_t             cp4_reg;
    logic [XPW-1:0]    xq_full, xt_full;
    logic [XQW-1:0]    xq5_reg, xt5_reg;

    logic [SECTOR_W-1:0] sector4;
    late_side_t        side4, side7;
    logic [QQW-1:0]    qq7, qt7;
    logic [RW-1:0]     rq7_unused, rt7_unused;
    chan_t             cq7, ct7;

    chan_t red_next, green_next, blue_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // one enable for the whole pipeline: move unless the output is blocked
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce && aresetn;

    assign hue0   = s_tdata[HUE_W-1:0];
    assign sat0   = s_tdata[HUE_W +: FRAC_W];
    assign val0   = s_tdata[HUE_W + FRAC_W +: FRAC_W];
    assign sat_c0 = (sat0 > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : sat0;

    // hue / span: quotient counts sectors, remainder is the position in it
    hsv2rgb_cdiv #(.XW(HUE_W), .DIV(SPAN)) u_div_hue (
        .aclk (aclk),
        .ce   (ce),
        .x    (hue0),
        .q    (qh2),
        .r    (rh2)
    );

    hsv2rgb_delay #(.W(2 * FRAC_W), .N(2)) u_dly_sv (
        .aclk (aclk),
        .ce   (ce),
        .din  ({sat_c0, val0}),
        .dout ({sat2, val2})
    );

    // sector count mod 6 folds whole turns away
    hsv2rgb_cdiv #(.XW(QHW), .DIV(SECTOR_COUNT)) u_div_sec (
        .aclk (aclk),
        .ce   (ce),
        .x    (qh2),
        .q    (),
        .r    (sector4)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            sr3_reg   <= NUMW'(sat2 * rh2);
            sdr3_reg  <= NUMW'(sat2 * (RW'(SPAN) - rh2));
            pp3_reg   <= PPW'(val2 * (FRAC_W'(FRAC_ONE) - sat2));
            val3_reg  <= val2;
            numq4_reg <= NUM_FULL - sr3_reg;
            numt4_reg <= NUM_FULL - sdr3_reg;
            cp4_reg   <= sat_byte10(pp3_reg[PPW-1:FRAC_W-1]);
            val4_reg  <= val3_reg;
            xq5_reg   <= xq_full[XPW-1:FRAC_W-1];
            xt5_reg   <= xt_full[XPW-1:FRAC_W-1];
        end
    end

    assign xq_full = XPW'(val4_reg) * XPW'(numq4_reg);
    assign xt_full = XPW'(val4_reg) * XPW'(numt4_reg);

    assign side4.sector = sector4;
    assign side4.cv     = sat_byte10({1'b0, val4_reg});
    assign side4.cp     = cp4_reg;

    hsv2rgb_delay #(.W($bits(late_side_t)), .N(3)) u_dly_side (
        .aclk (aclk),
        .ce   (ce),
        .din  (side4),
        .dout (side7)
    );

    hsv2rgb_cdiv #(.XW(XQW), .DIV(SPAN)) u_div_q (
        .aclk (aclk),
        .ce   (ce),
        .x    (xq5_reg),
        .q    (qq7),
        .r    (rq7_unused)
    );

    hsv2rgb_cdiv #(.XW(XQW), .DIV(SPAN)) u_div_t (
        .aclk (aclk),
        .ce   (ce),
        .x    (xt5_reg),
        .q    (qt7),
        .r    (rt7_unused)
    );

    assign cq7 = (qq7 > QQW'(CH_MAX)) ? chan_t'(CH_MAX) : qq7[CH_W-1:0];
    assign ct7 = (qt7 > QQW'(CH_MAX)) ? chan_t'(CH_MAX) : qt7[CH_W-1:0];

    always_comb begin
        case (side7.sector)
            SECTOR_RED_YEL: begin
                red_next = side7.cv; green_next = ct7;      blue_next = side7.cp;
            end
            SECTOR_YEL_GRN: begin
                red_next = cq7;      green_next = side7.cv; blue_next = side7.cp;
            end
            SECTOR_GRN_CYN: begin
                red_next = side7.cp; green_next = side7.cv; blue_next = ct7;
            end
            SECTOR_CYN_BLU: begin
                red_next = side7.cp; green_next = cq7;      blue_next = side7.cv;
            end
            SECTOR_BLU_MAG: begin
                red_next = ct7;      green_next = side7.cp; blue_next = side7.cv;
            end
            default: begin
                red_next = side7.cv; green_next = side7.cp; blue_next = cq7;
            end
        endcase
    end

    assign vld_next      = {vld_reg[VLD_N-2:0], s_tvalid};
    assign m_tvalid_next = vld_reg[VLD_N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {blue_next, green_next, red_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // p is the smallest and v the largest of the channel candidates
    `HSV2RGB_ASSERT_SAME(a_p_is_min, aclk, aresetn, vld_reg[VLD_N-1],
        (side7.cp <= cq7) && (side7.cp <= ct7), "p above q or t")
    `HSV2RGB_ASSERT_SAME(a_v_is_max, aclk, aresetn, vld_reg[VLD_N-1],
        (side7.cv >= cq7) && (side7.cv >= ct7), "v below q or t")
    `HSV2RGB_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready,
        $stable(vld_reg), "pipeline moved during output stall")
    `HSV2RGB_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready,
        vld_reg[0], "accepted transaction missing from first stage")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import hsv2rgb_pkg::*;

    localparam int HUE_STEPS   = HUE_STEPS_DEFAULT;
    localparam int SECTOR_SPAN = DEG_PER_SECTOR * HUE_STEPS;
    localparam int CIRCLE_SPAN = SECTOR_COUNT * SECTOR_SPAN;
    localparam int RANDOM_COLORS = 500;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 80;
    localparam int PAUSE_AT      = 350;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIR_ROWS      = 22;

    // red in the low byte, as on m_tdata
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
        logic              typed;
        chan_t             red;
        chan_t             green;
        chan_t             blue;
    } color_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // hue[12:0], saturation[21:13], brightness[30:22]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // red[7:0], green[15:8], blue[23:16]

    pixel_t pending_pixels[$];
    int     pixel_errors = 0;
    int     colors_sent  = 0;
    int     cycle_count  = 0;
    int     hold_left    = 0;
    bit     hold_done    = 1'b0;
    int     burst_left   = 0;

    // hue, saturation, value, typed, red, green, blue
    color_row_t dir_rows [DIR_ROWS] = '{
        '{13'd0,    9'd0,   9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{13'd0,    9'd0,   9'd128, 1'b1, 8'd128, 8'd128, 8'd128},
        '{13'd3000, 9'd0,   9'd256, 1'b1, 8'd255, 8'd255, 8'd255},
        '{13'd8191, 9'd0,   9'd511, 1'b1, 8'd255, 8'd255, 8'd255},
        '{13'd0,    9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
        '{13'd960,  9'd256, 9'd256, 1'b1, 8'd255, 8'd255, 8'd0},
        '{13'd1920, 9'd256, 9'd256, 1'b1, 8'd0,   8'd255, 8'd0},
        '{13'd2880, 9'd256, 9'd256, 1'b1, 8'd0,   8'd255, 8'd255},
        '{13'd3840, 9'd256, 9'd256, 1'b1, 8'd0,   8'd0,   8'd255},
        '{13'd4800, 9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd255},
        '{13'd5760, 9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
        '{13'd5760, 9'd511, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
        '{13'd7680, 9'd256, 9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{13'd959,  9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd5759, 9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd8191, 9'd511, 9'd511, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd480,  9'd128, 9'd200, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd1440, 9'd200, 9'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd2400, 9'd64,  9'd511, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd4320, 9'd1,   9'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd5280, 9'd255, 9'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd6720, 9'd300, 9'd300, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    hsv_to_rgb_converter_core #(
        .HUE_STEPS_PER_DEGREE(HUE_STEPS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic chan_t clamp_byte(input longint unsigned x);
        return (x > 64'(CH_MAX)) ? chan_t'(CH_MAX) : chan_t'(x);
    endfunction

    function automatic pixel_t hsv_pixel(input logic [HUE_W-1:0] hue,
                                         input logic [FRAC_W-1:0] sat,
                                         input logic [FRAC_W-1:0] val);
        longint unsigned s, v, h, rem, den;
        logic [SECTOR_W-1:0] sector;
        chan_t cv, cp, cq, ct;
        pixel_t px;
        s = (sat > FRAC_W'(FRAC_ONE)) ? 64'(FRAC_ONE) : 64'(sat);
        v = 64'(val);
        h = 64'(hue) % 64'(CIRCLE_SPAN);
        sector = SECTOR_W'(h / 64'(SECTOR_SPAN));
        rem = h % 64'(SECTOR_SPAN);
        den = 64'(FRAC_ONE) * 64'(SECTOR_SPAN);
        cv = clamp_byte(v);
        cp = clamp_byte((v * (64'(FRAC_ONE) - s)) / 64'(FRAC_ONE));
        cq = clamp_byte((v * (den - s * rem)) / den);
        ct = clamp_byte((v * (den - s * (64'(SECTOR_SPAN) - rem))) / den);
        case (sector)
            SECTOR_RED_YEL: begin px.red = cv; px.green = ct; px.blue = cp; end
            SECTOR_YEL_GRN: begin px.red = cq; px.green = cv; px.blue = cp; end
            SECTOR_GRN_CYN: begin px.red = cp; px.green = cv; px.blue = ct; end
            SECTOR_CYN_BLU: begin px.red = cp; px.green = cq; px.blue = cv; end
            SECTOR_BLU_MAG: begin px.red = ct; px.green = cp; px.blue = cv; end
            default: begin px.red = cv; px.green = cp; px.blue = cq; end
        endcase
        return px;
    endfunction

    // bursts of back-to-back transactions with idle gaps in between
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(7) == 0) ? 40 : $urandom_range(24, 1);
            case ($urandom_range(3))
                0: gap = 0;
                1: gap = $urandom_range(3, 1);
                2: gap = $urandom_range(8, 1);
                default: gap = $urandom_range(20, 9);
            endcase
            // keep offering while the receiver holds off
            if (hold_left > 0)
                gap = 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic send_color(input logic [HUE_W-1:0] hue, input logic [FRAC_W-1:0] sat,
                              input logic [FRAC_W-1:0] val, input pixel_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, sat, hue};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(want);
        colors_sent++;
    endtask

    initial begin
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat, val;
        pixel_t want;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            pace_sender();
            if (dir_rows[i].typed) begin
                want.red   = dir_rows[i].red;
                want.green = dir_rows[i].green;
                want.blue  = dir_rows[i].blue;
            end else begin
                want = hsv_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].val);
            end
            send_color(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].val, want);
        end

        for (int i = 0; i < RANDOM_COLORS; i++) begin
            if (i == PAUSE_AT) begin
                // let the pipeline drain completely
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_pixels.size() != 0) @(posedge aclk);
            end
            pace_sender();
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    hue = HUE_W'($urandom_range(8191));
                    sat = FRAC_W'($urandom_range(511));
                    val = FRAC_W'($urandom_range(511));
                end
                5, 6, 7: begin
                    hue = HUE_W'($urandom_range(CIRCLE_SPAN - 1));
                    sat = FRAC_W'($urandom_range(FRAC_ONE));
                    val = FRAC_W'($urandom_range(FRAC_ONE));
                end
                default: begin
                    // near a sector boundary
                    hue = HUE_W'($urandom_range(SECTOR_COUNT) * SECTOR_SPAN);
                    case ($urandom_range(2))
                        0: hue = hue + HUE_W'(1);
                        1: hue = (hue == '0) ? '0 : hue - HUE_W'(1);
                        default: ;
                    endcase
                    sat = ($urandom_range(1) == 0) ? 9'(FRAC_ONE) : 9'($urandom_range(511));
                    val = FRAC_W'($urandom_range(511));
                end
            endcase
            send_color(hue, sat, val, hsv_pixel(hue, sat, val));
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pixel_errors == 0)
            $display("[hsv_to_rgb_converter_core] OK");
        else
            $display("[hsv_to_rgb_converter_core] ERROR");
        $finish;
    end

    // receiver: one long hold-off, otherwise a rotating stall pattern
    initial begin
        int rcv_cycle;
        rcv_cycle = 0;
        forever begin
            @(posedge aclk);
            rcv_cycle++;
            if (!hold_done && colors_sent >= DIR_ROWS + HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((rcv_cycle / 64) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(1) == 0);
                    2: m_tready <= ($urandom_range(9) == 0);
                    default: m_tready <= (rcv_cycle % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pixel_t'(m_tdata);
            if (pending_pixels.size() == 0) begin
                pixel_errors++;
                if (pixel_errors <= 10)
                    $display("mismatch: unexpected transaction r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue);
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                    pixel_errors++;
                    if (pixel_errors <= 10)
                        $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[hsv_to_rgb_converter_core] ERROR");
            $finish;
        end
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_cdiv.sv
rtl/core/hsv2rgb_delay.sv
rtl/core/hsv_to_rgb_converter_core.sv
tb/testbench.sv
